/* rtl/csr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csr_pkg
// Shared types, constants and table functions of the compressor speed
// regulator.
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int FREQ_W  = 10;
    localparam int TGT_W   = 9;
    localparam int DUTY_W  = 12;
    localparam int STEP_W  = 4;
    localparam int MIN_W   = 8;
    localparam int RATIO_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0]  TOP_STEP        = 4'd8;
    localparam logic [STEP_W-1:0]  STEP_RESET      = 4'd1;
    localparam logic [TGT_W-1:0]   TARGET_RESET    = 9'd108;
    localparam logic [RATIO_W-1:0] RATIO_RESET     = 8'd98;
    localparam logic [DUTY_W-1:0]  CEILING_RESET   = 12'd1220;
    localparam logic [DUTY_W-1:0]  FLOOR_RESET     = 12'd300;
    localparam logic [MIN_W-1:0]   MIN_SATURATE    = 8'd255;

    // running minutes at which the step rules act
    localparam logic [MIN_W-1:0] MIN_FIRST  = 8'd1;
    localparam logic [MIN_W-1:0] MIN_SECOND = 8'd30;
    localparam logic [MIN_W-1:0] MIN_THIRD  = 8'd80;
    localparam logic [MIN_W-1:0] MIN_FOURTH = 8'd100;
    localparam logic [MIN_W-1:0] MIN_FIFTH  = 8'd120;

    // running ratio thresholds
    localparam logic [RATIO_W-1:0] RATIO_HI   = 8'd75;
    localparam logic [RATIO_W-1:0] RATIO_MID  = 8'd63;
    localparam logic [RATIO_W-1:0] RATIO_LOW  = 8'd57;
    localparam logic [RATIO_W-1:0] RATIO_MIN  = 8'd51;

    // input mode codes
    localparam logic [1:0] MODE_SECOND = 2'd0;
    localparam logic [1:0] MODE_MINUTE = 2'd1;
    localparam logic [1:0] MODE_UP     = 2'd2;
    localparam logic [1:0] MODE_DOWN   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd2;

    typedef enum logic [1:0] {
        OP_SECOND,
        OP_MINUTE,
        OP_UP,
        OP_DOWN
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [FREQ_W-1:0] freq;
        logic              adjust;
    } cmd_t;

    function automatic logic [TGT_W-1:0] freq_of_step(input logic [STEP_W-1:0] s);
        logic [TGT_W-1:0] f;
        begin
            case (s)
                4'd0:    f = 9'd96;
                4'd1:    f = 9'd108;
                4'd2:    f = 9'd120;
                4'd3:    f = 9'd132;
                4'd4:    f = 9'd144;
                4'd5:    f = 9'd160;
                4'd6:    f = 9'd200;
                4'd7:    f = 9'd240;
                default: f = 9'd260;
            endcase
            return f;
        end
    endfunction

    // duty step chosen by error size, rising gets the larger coarse step
    function automatic logic [4:0] duty_tier(input logic [FREQ_W-1:0] err,
                                             input logic rising);
        logic [4:0] t;
        begin
            if (err > 10'd80)
                t = rising ? 5'd30 : 5'd15;
            else if (err > 10'd40)
                t = 5'd20;
            else if (err > 10'd20)
                t = 5'd15;
            else if (err > 10'd10)
                t = 5'd10;
            else if (err > 10'd2)
                t = 5'd5;
            else
                t = 5'd1;
            return t;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/compressor_speed_regulator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// compressor_speed_regulator
// Compressor motor speed regulator: duty control and speed step selection.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one word per tick or command:
//   mode 0 second tick with measured_frequency and spinning, mode 1 minute
//   tick, mode 2 speed up, mode 3 speed down.
//   output channel (out_valid/out_ready) returns exactly one word per input
//   word: duty, target_frequency and speed_index after that command.
//   configuration channel (cfg_valid/cfg_ready) writes running_ratio (0),
//   duty_ceiling (1) or duty_floor (2); cfg_ready is always high, writes
//   should land while no word is in flight.
//   path: a taken input word is written into the command queue, then executed
//   into the result registers once out_valid is low or out_ready is high.
//   throughput: one word per cycle while out_ready stays high.
//   a two-entry command queue lets input words be taken while the receiver
//   holds off out_ready; when it fills, in_ready drops until results drain.
//   reset: step 1, target 108, duty 300, minute count and last frequency 0,
//   registers back to their default values, queue and result empty.
// ----------------------------------------------------------------------------
module compressor_speed_regulator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        mode,
    input  wire logic [csr_pkg::FREQ_W-1:0]        measured_frequency,
    input  wire logic                              spinning,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [csr_pkg::DUTY_W-1:0]             duty,
    output logic [csr_pkg::TGT_W-1:0]              target_frequency,
    output logic [csr_pkg::STEP_W-1:0]             speed_index,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csr_pkg::DUTY_W-1:0]        cfg_data
);
    import csr_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head_cmd;

    assign cfg_ready = 1'b1;

    csr_front u_front (
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .measured_frequency (measured_frequency),
        .spinning           (spinning),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_cmd              (q_push_cmd)
    );

    csr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd)
    );

    csr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_cmd            (q_head_cmd),
        .q_pop            (q_pop),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .duty             (duty),
        .target_frequency (target_frequency),
        .speed_index      (speed_index)
    );

endmodule
`default_nettype wire

/* rtl/csr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csr_front
// Takes input words, decodes the mode into a command and pushes it into
// the command queue.
// ----------------------------------------------------------------------------
module csr_front (
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   mode,
    input  wire logic [csr_pkg::FREQ_W-1:0]   measured_frequency,
    input  wire logic                         spinning,
    input  wire logic                         q_full,
    output logic                              q_push,
    output csr_pkg::cmd_t                     q_cmd
);
    import csr_pkg::*;

    op_t op;

    always_comb
    begin
        case (mode)
            MODE_SECOND: op = OP_SECOND;
            MODE_MINUTE: op = OP_MINUTE;
            MODE_UP:     op = OP_UP;
            MODE_DOWN:   op = OP_DOWN;
            default:     op = OP_DOWN;
        endcase
    end

    assign in_ready     = ~q_full;
    assign q_push       = in_valid & ~q_full;
    assign q_cmd.op     = op;
    assign q_cmd.freq   = measured_frequency;
    // only a second tick with the motor running moves the duty
    assign q_cmd.adjust = (op == OP_SECOND) & spinning;

endmodule
`default_nettype wire

/* rtl/csr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csr_queue
// Two-entry command queue between the decoder and the execution stage.
// ----------------------------------------------------------------------------
module csr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire csr_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output csr_pkg::cmd_t       head_cmd
);
    import csr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

/* rtl/csr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csr_back
// Executes commands: duty regulation, minute counting, speed step moves.
// Holds the regulator state, the configuration registers and the result.
// ----------------------------------------------------------------------------
module csr_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_not_empty,
    input  wire csr_pkg::cmd_t                    q_cmd,
    output logic                                  q_pop,
    input  wire logic                             cfg_we,
    input  wire logic [csr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csr_pkg::DUTY_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [csr_pkg::DUTY_W-1:0]            duty,
    output logic [csr_pkg::TGT_W-1:0]             target_frequency,
    output logic [csr_pkg::STEP_W-1:0]            speed_index
);
    import csr_pkg::*;

    logic [RATIO_W-1:0] ratio_reg;
    logic [DUTY_W-1:0]  ceiling_reg;
    logic [DUTY_W-1:0]  floor_reg;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [TGT_W-1:0]   target_reg;
    logic [TGT_W-1:0]   target_next;
    logic [DUTY_W-1:0]  duty_reg;
    logic [DUTY_W-1:0]  duty_next;
    logic [MIN_W-1:0]   minutes_reg;
    logic [MIN_W-1:0]   minutes_next;
    logic [FREQ_W-1:0]  last_freq_reg;
    logic [FREQ_W-1:0]  last_freq_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [FREQ_W-1:0]  tgt_ext;
    logic               below;
    logic               above;
    logic [FREQ_W-1:0]  err;
    logic [4:0]         tier;
    logic [DUTY_W:0]    duty_up;
    logic [DUTY_W:0]    duty_dn;
    logic [DUTY_W-1:0]  adj_duty;
    logic [STEP_W:0]    step_req;
    logic [STEP_W-1:0]  step_sat;
    logic               step_set;

    assign q_pop = q_not_empty & (~out_valid_reg | out_ready);

    // duty regulation against the incoming frequency
    always_comb
    begin
        tgt_ext = {1'b0, target_reg};
        below   = q_cmd.freq < tgt_ext;
        above   = q_cmd.freq > tgt_ext;
        err     = below ? (tgt_ext - q_cmd.freq) : (q_cmd.freq - tgt_ext);
        tier    = duty_tier(err, below);
        duty_up = {1'b0, duty_reg} + {{(DUTY_W-4){1'b0}}, tier};
        duty_dn = {1'b0, duty_reg} - {{(DUTY_W-4){1'b0}}, tier};
        if (below)
            adj_duty = (duty_up > {1'b0, ceiling_reg}) ? ceiling_reg : duty_up[DUTY_W-1:0];
        else if (above)
            adj_duty = (duty_dn[DUTY_W] || (duty_dn[DUTY_W-1:0] < floor_reg))
                       ? floor_reg : duty_dn[DUTY_W-1:0];
        else
            adj_duty = duty_reg;
    end

    always_comb
    begin
        last_freq_next = last_freq_reg;
        duty_next      = duty_reg;
        minutes_next   = minutes_reg;
        step_req       = {1'b0, step_reg};
        step_set       = 1'b0;
        case (q_cmd.op)
            OP_SECOND:
            begin
                last_freq_next = q_cmd.freq;
                if (q_cmd.adjust)
                    duty_next = adj_duty;
            end
            OP_MINUTE:
            begin
                if (last_freq_reg != '0)
                    minutes_next = (minutes_reg == MIN_SATURATE) ? minutes_reg
                                   : minutes_reg + 8'd1;
                else
                    minutes_next = '0;
                if (minutes_next == MIN_FIFTH || minutes_next == MIN_FOURTH)
                begin
                    step_req = {1'b0, step_reg} + 5'd3;
                    step_set = 1'b1;
                end
                else if (minutes_next == MIN_THIRD)
                begin
                    step_req = {1'b0, step_reg} + 5'd2;
                    step_set = 1'b1;
                end
                else if (minutes_next == MIN_SECOND)
                begin
                    step_set = 1'b1;
                    if (ratio_reg > RATIO_HI)       step_req = 5'd8;
                    else if (ratio_reg > RATIO_MID) step_req = 5'd6;
                    else if (ratio_reg > RATIO_LOW) step_req = 5'd4;
                    else if (ratio_reg > RATIO_MIN) step_req = 5'd2;
                    else                            step_req = 5'd0;
                end
                else if (minutes_next == MIN_FIRST)
                begin
                    step_set = 1'b1;
                    if (ratio_reg > RATIO_HI)       step_req = 5'd8;
                    else if (ratio_reg > RATIO_MID) step_req = 5'd7;
                    else if (ratio_reg > RATIO_LOW) step_req = 5'd6;
                    else if (ratio_reg > RATIO_MIN) step_req = 5'd5;
                    else                            step_req = 5'd4;
                end
            end
            OP_UP:
            begin
                step_req = {1'b0, step_reg} + 5'd1;
                step_set = 1'b1;
            end
            OP_DOWN:
            begin
                step_req = (step_reg != '0) ? ({1'b0, step_reg} - 5'd1) : 5'd0;
                step_set = 1'b1;
            end
            default:
            begin
                step_set = 1'b0;
            end
        endcase
        step_sat    = (step_req > {1'b0, TOP_STEP}) ? TOP_STEP : step_req[STEP_W-1:0];
        step_next   = step_set ? step_sat : step_reg;
        target_next = step_set ? freq_of_step(step_sat) : target_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            ceiling_reg   <= CEILING_RESET;
            floor_reg     <= FLOOR_RESET;
            step_reg      <= STEP_RESET;
            target_reg    <= TARGET_RESET;
            duty_reg      <= FLOOR_RESET;
            minutes_reg   <= '0;
            last_freq_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RATIO:   ratio_reg   <= cfg_data[RATIO_W-1:0];
                    CFG_CEILING: ceiling_reg <= cfg_data;
                    CFG_FLOOR:   floor_reg   <= cfg_data;
                    default:     ratio_reg   <= ratio_reg;
                endcase
            end
            // state only moves when a command is taken, so it doubles as the result word
            if (q_pop)
            begin
                step_reg      <= step_next;
                target_reg    <= target_next;
                duty_reg      <= duty_next;
                minutes_reg   <= minutes_next;
                last_freq_reg <= last_freq_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign duty             = duty_reg;
    assign target_frequency = target_reg;
    assign speed_index      = step_reg;

endmodule
`default_nettype wire
